### rtl/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
// Depends on nothing; every other file of the block imports it.
package spq_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 4;

    // Operation carried by a request.
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    // Outcome reported with each result.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Sequencer states of the queue engine.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_PUT,
        S_REM_HEAD,
        S_REM_SHIFT,
        S_DONE
    } t_state;

    // One finished result, handed from the engine to the output register.
    typedef struct packed {
        logic signed [VALUE_W-1:0] removed_value;
        t_status                   status;
        logic [OCC_W-1:0]          occupancy;
        logic                      is_full;
        logic                      is_empty;
    } t_result;

endpackage

### rtl/spq_in_if.sv
// Request channel of the sorted priority queue: valid, ready and payload.
// Depends on spq_pkg for the field widths.
interface spq_in_if
    import spq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

### rtl/spq_out_if.sv
// Result channel of the sorted priority queue: valid, ready and payload.
// Depends on spq_pkg for the field widths.
interface spq_out_if
    import spq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] removed_value;
    logic [STATUS_W-1:0]       status;
    logic [OCC_W-1:0]          occupancy;
    logic                      is_full;
    logic                      is_empty;

    modport source (output valid, output removed_value, output status, output occupancy,
                    output is_full, output is_empty, input ready);
    modport sink   (input valid, input removed_value, input status, input occupancy,
                    input is_full, input is_empty, output ready);
endinterface

### rtl/spq_engine.sv
// Queue engine: entry memory, occupancy count and the sequencer that walks it.
// Depends on spq_pkg; instantiated by sorted_priority_queue_top.
module spq_engine
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_cmd,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_out_free,
    output logic                      o_idle,
    output logic                      o_done,
    output t_result                   o_result
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_idx, n_idx;
    t_cmd                      r_cmd, n_cmd;
    logic signed [VALUE_W-1:0] r_value, n_value;
    t_status                   r_status, n_status;
    logic signed [VALUE_W-1:0] r_removed, n_removed;

    logic signed [VALUE_W-1:0] r_mem [QUEUE_DEPTH];
    logic signed [VALUE_W-1:0] r_rd_data;
    logic                      w_rd_en;
    logic [AW-1:0]             w_rd_addr;
    logic                      w_wr_en;
    logic [AW-1:0]             w_wr_addr;
    logic signed [VALUE_W-1:0] w_wr_data;

    logic [CW-1:0]             w_cnt_m1;
    logic [CW-1:0]             w_idx_m2;
    logic [CW-1:0]             w_idx_p1;
    logic [CW:0]               w_idx_p2;
    logic                      w_is_full;
    logic                      w_is_empty;
    logic                      w_greater;
    logic [31:0]               w_occ_ext;

    assign w_cnt_m1   = r_count - CW'(1);
    assign w_idx_m2   = r_idx - CW'(2);
    assign w_idx_p1   = r_idx + CW'(1);
    assign w_idx_p2   = {1'b0, r_idx} + (CW + 1)'(2);
    assign w_is_full  = (r_count == CW'(QUEUE_DEPTH));
    assign w_is_empty = (r_count == '0);
    // The new value moves ahead only of strictly smaller entries.
    assign w_greater  = (r_value > r_rd_data);

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (t_cmd'(i_cmd) == CMD_INSERT) begin
                        n_state = (w_is_full || w_is_empty) ? S_DONE : S_INS;
                    end else begin
                        n_state = w_is_empty ? S_DONE : S_REM_HEAD;
                    end
                end
            end
            S_INS: begin
                if (!w_greater) begin
                    n_state = S_DONE;
                end else if (r_idx == CW'(1)) begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT:   n_state = S_DONE;
            S_REM_HEAD:  n_state = (r_count > CW'(1)) ? S_REM_SHIFT : S_DONE;
            S_REM_SHIFT: begin
                if (w_idx_p2 >= {1'b0, r_count}) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory accesses and working registers for each state.
    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_cmd     = r_cmd;
        n_value   = r_value;
        n_status  = r_status;
        n_removed = r_removed;
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        w_wr_en   = 1'b0;
        w_wr_addr = '0;
        w_wr_data = r_value;
        o_done    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd     = t_cmd'(i_cmd);
                    n_value   = i_value;
                    n_status  = ST_OK;
                    n_removed = '0;
                    n_idx     = r_count;
                    if (t_cmd'(i_cmd) == CMD_INSERT) begin
                        if (w_is_full) begin
                            n_status = ST_FULL;
                        end else if (w_is_empty) begin
                            // First entry goes straight to the head.
                            w_wr_en   = 1'b1;
                            w_wr_data = i_value;
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = w_cnt_m1[AW-1:0];
                        end
                    end else begin
                        if (w_is_empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            w_rd_en = 1'b1;
                        end
                    end
                end
            end
            S_INS: begin
                // Shift a smaller entry back by one, or drop the value in place.
                w_wr_en   = 1'b1;
                w_wr_addr = r_idx[AW-1:0];
                if (w_greater) begin
                    w_wr_data = r_rd_data;
                    n_idx     = r_idx - CW'(1);
                    if (r_idx != CW'(1)) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_idx_m2[AW-1:0];
                    end
                end
            end
            S_INS_PUT: begin
                w_wr_en = 1'b1;
            end
            S_REM_HEAD: begin
                n_removed = r_rd_data;
                n_idx     = '0;
                if (r_count > CW'(1)) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = AW'(1);
                end
            end
            S_REM_SHIFT: begin
                // Move entry idx+1 forward while entry idx+2 is fetched.
                w_wr_en   = 1'b1;
                w_wr_addr = r_idx[AW-1:0];
                w_wr_data = r_rd_data;
                if (w_idx_p2 < {1'b0, r_count}) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_idx_p2[AW-1:0];
                    n_idx     = w_idx_p1;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done = 1'b1;
                    if (r_status == ST_OK) begin
                        n_count = (r_cmd == CMD_INSERT) ? r_count + CW'(1) : w_cnt_m1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Result as it stands after the occupancy update.
    assign w_occ_ext              = 32'(n_count);
    assign o_result.removed_value = r_removed;
    assign o_result.status        = r_status;
    assign o_result.occupancy     = w_occ_ext[OCC_W-1:0];
    assign o_result.is_full       = (n_count == CW'(QUEUE_DEPTH));
    assign o_result.is_empty      = (n_count == '0);
    assign o_idle                 = (r_state == S_IDLE);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cmd     <= n_cmd;
        r_value   <= n_value;
        r_status  <= n_status;
        r_removed <= n_removed;
    end

endmodule

### rtl/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: request and result channels and the
// output register. Depends on spq_pkg, spq_in_if, spq_out_if and spq_engine.
//
//   Channel   Direction  Payload
//   i_req     in         cmd (insert or remove), value
//   o_rsp     out        removed_value, status, occupancy, is_full, is_empty
//
// One request is worked at a time by a walk of the entry memory.
// A rejected insert, an insert into an empty queue or a remove from an empty queue
// goes straight to the done state; any other insert shifts each smaller entry back
// by one, and a remove moves every entry behind the head forward by one.
// The memory walk moves one entry per cycle.
// Reset empties the queue at once; no clearing pass is needed.
// A new request is taken while a result still waits in the output register; the
// engine then holds its last cycle until that register is free.
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spq_in_if.sink     i_req,
    spq_out_if.source  o_rsp
);

    logic    r_out_valid;
    t_result r_out;
    logic    w_out_free;
    logic    w_idle;
    logic    w_done;
    logic    w_start;
    t_result w_result;

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_start    = i_req.valid && i_req.ready;
    assign i_req.ready = w_idle;

    spq_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_cmd      (i_req.cmd),
        .i_value    (i_req.value),
        .i_out_free (w_out_free),
        .o_idle     (w_idle),
        .o_done     (w_done),
        .o_result   (w_result)
    );

    // Output register: loaded when the engine finishes, cleared when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_result;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.removed_value = r_out.removed_value;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.occupancy     = r_out.occupancy;
    assign o_rsp.is_full       = r_out.is_full;
    assign o_rsp.is_empty      = r_out.is_empty;

    // A finished result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> w_out_free)
        else $error("result completed while output register held");

    // A request is never accepted in the same cycle as a completion.
    a_accept_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> !w_done)
        else $error("request accepted while engine completing");

    // A rejected insert always reports a full queue.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_FULL) |-> r_out.is_full)
        else $error("full status without full flag");

    // A failed remove always reports an empty queue.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_EMPTY) |-> r_out.is_empty)
        else $error("empty status without empty flag");

endmodule
